// ===== design/porc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// porc_pkg: shared types and constants of the output record checker
// Holds record state, result and register-file types, the register indexes,
// byte positions and the fixed push opcodes of the key scripts.
// ----------------------------------------------------------------------------
package porc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_HASH_LOCK = 2'd0;
  localparam logic [1:0] REG_EQUAL     = 2'd1;
  localparam logic [1:0] REG_SCHNORR   = 2'd2;
  localparam logic [1:0] REG_ECDSA     = 2'd3;

  // Register reset values
  localparam logic [7:0] RST_HASH_LOCK = 8'd170;
  localparam logic [7:0] RST_EQUAL     = 8'd135;
  localparam logic [7:0] RST_SCHNORR   = 8'd172;
  localparam logic [7:0] RST_ECDSA     = 8'd171;

  // Fixed push opcodes
  localparam logic [7:0] OP_PUSH32 = 8'h20;
  localparam logic [7:0] OP_PUSH33 = 8'h21;

  // Byte positions within a record
  localparam logic [5:0] POS_AMT_LAST     = 6'd7;
  localparam logic [5:0] POS_FIRST_SCRIPT = 6'd8;
  localparam logic [5:0] POS_HASH_SECOND  = 6'd9;
  localparam logic [5:0] POS_SCHNORR_LAST = 6'd41;
  localparam logic [5:0] POS_LONG_LAST    = 6'd42;
  localparam logic [5:0] POS_MAX          = 6'd63;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_AMT_SHORT = 2'd1,
    STATUS_BAD_SCRIPT = 2'd2,
    STATUS_TRAILING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_HASH    = 2'd1,
    KIND_SCHNORR = 2'd2,
    KIND_ECDSA   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] hash_lock;
    logic [7:0] equal;
    logic [7:0] schnorr;
    logic [7:0] ecdsa;
  } cfg_t;

  typedef struct packed {
    logic [5:0]  pos;
    logic [63:0] amount;
    kind_e       kind;
    status_e     fault;
  } rec_state_t;

  typedef struct packed {
    logic [7:0]  script_byte;
    logic        fwd;
    logic        done;
    status_e     status;
    logic [63:0] amount;
    kind_e       kind;
  } result_t;

  // Position of the closing opcode for a script kind
  function automatic logic [5:0] script_last(kind_e kind);
    script_last = (kind == KIND_SCHNORR) ? POS_SCHNORR_LAST : POS_LONG_LAST;
  endfunction

endpackage

// ===== design/porc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// porc_step: per-byte record step
// Works out the next record state and the result transaction for one byte:
// amount gathering, script classification, fault latching and close-out.
// ----------------------------------------------------------------------------
module porc_step (
  input  porc_pkg::rec_state_t st_i,
  input  porc_pkg::cfg_t       cfg_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 final_byte_i,
  output porc_pkg::rec_state_t st_o,
  output porc_pkg::result_t    res_o
);
  import porc_pkg::*;

  rec_state_t upd;
  logic       fwd;
  logic [5:0] last;
  logic [7:0] closing;

  // Closing opcode and last position of the kind seen so far
  assign last = script_last(st_i.kind);

  always_comb begin
    case (st_i.kind)
      KIND_HASH:    closing = cfg_i.equal;
      KIND_SCHNORR: closing = cfg_i.schnorr;
      default:      closing = cfg_i.ecdsa;
    endcase
  end

  // Advance the record by one byte
  always_comb begin
    upd = st_i;
    fwd = 1'b0;
    if (st_i.pos <= POS_AMT_LAST) begin
      upd.amount = {st_i.amount[55:0], in_byte_i};
    end else if (st_i.pos == POS_FIRST_SCRIPT) begin
      fwd = 1'b1;
      if (st_i.fault == STATUS_OK) begin
        if (in_byte_i == cfg_i.hash_lock) begin
          upd.kind = KIND_HASH;
        end else if (in_byte_i == OP_PUSH32) begin
          upd.kind = KIND_SCHNORR;
        end else if (in_byte_i == OP_PUSH33) begin
          upd.kind = KIND_ECDSA;
        end else begin
          upd.fault = STATUS_BAD_SCRIPT;
          upd.kind  = KIND_NONE;
        end
      end
    end else if (st_i.fault == STATUS_OK && st_i.kind != KIND_NONE) begin
      if (st_i.pos > last) begin
        upd.fault = STATUS_TRAILING;
      end else begin
        fwd = 1'b1;
        if (st_i.kind == KIND_HASH && st_i.pos == POS_HASH_SECOND
            && in_byte_i != OP_PUSH32) begin
          upd.fault = STATUS_BAD_SCRIPT;
          upd.kind  = KIND_NONE;
        end else if (st_i.pos == last && in_byte_i != closing) begin
          upd.fault = STATUS_BAD_SCRIPT;
          upd.kind  = KIND_NONE;
        end
      end
    end

    // Close out the record on its final byte
    if (final_byte_i && upd.fault == STATUS_OK) begin
      if (st_i.pos < POS_AMT_LAST) begin
        upd.fault = STATUS_AMT_SHORT;
      end else if (upd.kind == KIND_NONE || st_i.pos < script_last(upd.kind)) begin
        upd.fault = STATUS_BAD_SCRIPT;
        upd.kind  = KIND_NONE;
      end
    end
  end

  // Build the result transaction
  always_comb begin
    res_o.script_byte = fwd ? in_byte_i : 8'd0;
    res_o.fwd         = fwd;
    res_o.done        = final_byte_i;
    res_o.status      = final_byte_i ? upd.fault : STATUS_OK;
    res_o.amount      = (final_byte_i && upd.fault != STATUS_AMT_SHORT) ?
                        upd.amount : 64'd0;
    res_o.kind        = final_byte_i ? upd.kind : KIND_NONE;
  end

  // Clear on the final byte, otherwise step the saturating position
  always_comb begin
    st_o = upd;
    if (final_byte_i) begin
      st_o.pos    = 6'd0;
      st_o.amount = 64'd0;
      st_o.kind   = KIND_NONE;
      st_o.fault  = STATUS_OK;
    end else if (st_i.pos < POS_MAX) begin
      st_o.pos = st_i.pos + 6'd1;
    end
  end

endmodule

// ===== design/payment_output_record_checker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// payment_output_record_checker_core: output record checker
// Streams one output record a byte per transaction, gathers the amount,
// classifies the locking script and reports status on the final byte.
// ----------------------------------------------------------------------------
// Each accepted byte gives exactly one registered result transaction. The
// block takes one byte every clock unless the skid entry is full: a byte's
// step is short combinational logic between the record state registers and
// the result register, and a one-entry skid stage behind that register keeps
// input acceptance going for one byte while the result side stalls. The user
// must write the opcode registers via the plain write port only while idle; the block does not enforce it.
module payment_output_record_checker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  script_byte_o,
  output logic        script_byte_valid_o,
  output logic        record_done_o,
  output logic [1:0]  status_o,
  output logic [63:0] amount_o,
  output logic [1:0]  script_kind_o
);
  import porc_pkg::*;

  cfg_t       cfg_q;
  rec_state_t st_q, st_d;
  result_t    res;
  result_t    out_q, skid_q;
  logic       out_vld_q, skid_vld_q;
  logic       accept_in, out_take;

  assign in_stall_o = skid_vld_q;
  assign accept_in  = in_valid_i && !skid_vld_q;
  assign out_take   = out_vld_q && !out_stall_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hash_lock <= RST_HASH_LOCK;
      cfg_q.equal     <= RST_EQUAL;
      cfg_q.schnorr   <= RST_SCHNORR;
      cfg_q.ecdsa     <= RST_ECDSA;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HASH_LOCK: cfg_q.hash_lock <= cfg_wdata_i;
        REG_EQUAL:     cfg_q.equal     <= cfg_wdata_i;
        REG_SCHNORR:   cfg_q.schnorr   <= cfg_wdata_i;
        REG_ECDSA:     cfg_q.ecdsa     <= cfg_wdata_i;
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  porc_step u_step (
    .st_i         (st_q),
    .cfg_i        (cfg_q),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .st_o         (st_d),
    .res_o        (res)
  );

  // Record state: advance on every accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.pos    <= 6'd0;
      st_q.amount <= 64'd0;
      st_q.kind   <= KIND_NONE;
      st_q.fault  <= STATUS_OK;
    end else if (accept_in) begin
      st_q <= st_d;
    end
  end

  // Result register and skid stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_take) begin
      out_vld_q  <= skid_vld_q || accept_in;
      skid_vld_q <= 1'b0;
    end else if (accept_in) begin
      skid_vld_q <= 1'b1;
    end
  end

  // Result and skid payload: load from skid first, hold while stalled
  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_take) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (accept_in) begin
      skid_q <= res;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign script_byte_o       = out_q.script_byte;
  assign script_byte_valid_o = out_q.fwd;
  assign record_done_o       = out_q.done;
  assign status_o            = out_q.status;
  assign amount_o            = out_q.amount;
  assign script_kind_o       = out_q.kind;

  // Skid entry only fills behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid with empty result register");

  // Amount bytes are never forwarded as script bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in && st_q.pos <= POS_AMT_LAST |-> !res.fwd)
    else $error("amount byte forwarded as script byte");

  // Final byte returns the record state to its cleared form
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in && final_byte_i |=> st_q.pos == 6'd0 && st_q.fault == STATUS_OK)
    else $error("record state not cleared after final byte");

  // Position saturates on long records
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in && !final_byte_i && st_q.pos == POS_MAX |=> st_q.pos == POS_MAX)
    else $error("byte position wrapped past saturation");

  // Mid-record results carry no summary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.done |->
      out_q.status == STATUS_OK && out_q.kind == KIND_NONE && out_q.amount == 64'd0)
    else $error("summary fields set on a mid-record result");

endmodule
